/* hdl/length_prefixed_frame_receiver_macros.svh */
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_macros
// assertion macros of the frame receiver module
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpfr assertion failed");

// next-cycle implication, checked outside reset
`define LPFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpfr assertion failed");

`endif

/* hdl/lpfr_pkg.sv */
// ----------------------------------------------------------------------------
// lpfr_pkg
// widths, frame markers and result kinds of the frame receiver
// ----------------------------------------------------------------------------
package lpfr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    localparam logic [BYTE_W-1:0] MARK_HASH = 8'h23;
    localparam logic [BYTE_W-1:0] MARK_BANG = 8'h21;
    localparam logic [BYTE_W-1:0] MARK_STAR = 8'h2A;
    localparam logic [BYTE_W-1:0] MARK_AMP  = 8'h26;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_DONE    = 2'd2
    } kind_t;

endpackage

/* hdl/lpfr_if.sv */
// ----------------------------------------------------------------------------
// lpfr_if
// valid/ready channels of the frame receiver: byte input and result output
// ----------------------------------------------------------------------------
interface lpfr_byte_if;
    logic                        valid;
    logic                        ready;
    logic [lpfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfr_result_if;
    logic                        valid;
    logic                        ready;
    lpfr_pkg::kind_t             kind;
    logic [lpfr_pkg::LEN_W-1:0]  payload_index;
    logic [lpfr_pkg::BYTE_W-1:0] payload_byte;
    logic [lpfr_pkg::LEN_W-1:0]  frame_length;
    logic [lpfr_pkg::BYTE_W-1:0] check_byte;

    modport source (output valid, output kind, output payload_index, output payload_byte,
                    output frame_length, output check_byte, input ready);
    modport sink   (input valid, input kind, input payload_index, input payload_byte,
                    input frame_length, input check_byte, output ready);
endinterface

/* hdl/length_prefixed_frame_receiver.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// follows '#' '!' len_hi len_lo payload '*' check '&' frames byte by byte
// ----------------------------------------------------------------------------
// usage
//   rx carries one received byte per transaction; result returns exactly one
//   transaction per accepted byte: kind none, payload byte with its index, or
//   frame complete with the declared length and the captured check byte
//   fields that do not belong to the kind are zero
//   the result is registered: it is valid the cycle after its byte is accepted
//   throughput: one byte per cycle; the frame state updates in the same cycle
//   a byte is taken, and a single result register holds the answer
//   stall: while a result waits and result.ready is low, rx.ready is low; a
//   result taken in the same cycle frees the register for the next byte
//   reset: rst_n low returns to waiting for '#', clears length, count and
//   check byte, and drops result.valid
//   the check byte is not verified; a zero length skips the payload phase
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver
(
    input  logic          clk,
    input  logic          rst_n,
    lpfr_byte_if.sink     rx,
    lpfr_result_if.source result
);

`include "length_prefixed_frame_receiver_macros.svh"

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_BANG    = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_STAR    = 3'd5,
        PH_CHECK   = 3'd6,
        PH_AMP     = 3'd7
    } phase_t;

    localparam int LW = lpfr_pkg::LEN_W;
    localparam int BW = lpfr_pkg::BYTE_W;

    phase_t          phase_reg,  phase_next;
    logic [LW-1:0]   length_reg, length_next;
    logic [LW-1:0]   count_reg,  count_next;
    logic [BW-1:0]   check_reg,  check_next;

    logic            out_valid_reg;
    lpfr_pkg::kind_t kind_reg,   kind_next;
    logic [LW-1:0]   pidx_reg,   pidx_next;
    logic [BW-1:0]   pbyte_reg,  pbyte_next;
    logic [LW-1:0]   flen_reg,   flen_next;
    logic [BW-1:0]   chk_reg,    chk_next;

    logic            accept;
    logic [BW-1:0]   b;
    logic [LW-1:0]   len_lo_value;
    logic            last_payload;

    assign rx.ready = !out_valid_reg || result.ready;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;

    assign len_lo_value = {length_reg[LW-1:BW], b};
    assign last_payload = ({1'b0, count_reg} + {{LW{1'b0}}, 1'b1}) >= {1'b0, length_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        check_next  = check_reg;
        kind_next   = lpfr_pkg::KIND_NONE;
        pidx_next   = '0;
        pbyte_next  = '0;
        flen_next   = '0;
        chk_next    = '0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (b == lpfr_pkg::MARK_HASH)
                begin
                    phase_next = PH_BANG;
                end
            end
            PH_BANG:
            begin
                if (b == lpfr_pkg::MARK_BANG)
                begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                length_next = {b, {(LW-BW){1'b0}}};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = len_lo_value;
                count_next  = '0;
                phase_next  = (len_lo_value == '0) ? PH_STAR : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                kind_next  = lpfr_pkg::KIND_PAYLOAD;
                pidx_next  = count_reg;
                pbyte_next = b;
                if (last_payload)
                begin
                    count_next = '0;
                    phase_next = PH_STAR;
                end
                else
                begin
                    count_next = count_reg + {{(LW-1){1'b0}}, 1'b1};
                end
            end
            PH_STAR:
            begin
                if (b == lpfr_pkg::MARK_STAR)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                check_next = b;
                phase_next = PH_AMP;
            end
            PH_AMP:
            begin
                if (b == lpfr_pkg::MARK_AMP)
                begin
                    kind_next  = lpfr_pkg::KIND_DONE;
                    flen_next  = length_reg;
                    chk_next   = check_reg;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            length_reg    <= '0;
            count_reg     <= '0;
            check_reg     <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= lpfr_pkg::KIND_NONE;
            pidx_reg      <= '0;
            pbyte_reg     <= '0;
            flen_reg      <= '0;
            chk_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                length_reg    <= length_next;
                count_reg     <= count_next;
                check_reg     <= check_next;
                out_valid_reg <= 1'b1;
                kind_reg      <= kind_next;
                pidx_reg      <= pidx_next;
                pbyte_reg     <= pbyte_next;
                flen_reg      <= flen_next;
                chk_reg       <= chk_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.kind          = kind_reg;
    assign result.payload_index = pidx_reg;
    assign result.payload_byte  = pbyte_reg;
    assign result.frame_length  = flen_reg;
    assign result.check_byte    = chk_reg;

    `LPFR_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_reg)
    `LPFR_ASSERT_NEXT(a_payload_kind, clk, rst_n, accept && phase_reg == PH_PAYLOAD,
                      kind_reg == lpfr_pkg::KIND_PAYLOAD)
    `LPFR_ASSERT_IMPL(a_payload_len_nonzero, clk, rst_n, phase_reg == PH_PAYLOAD,
                      length_reg != '0 && count_reg < length_reg)
    `LPFR_ASSERT_IMPL(a_none_fields_zero, clk, rst_n,
                      out_valid_reg && kind_reg == lpfr_pkg::KIND_NONE,
                      pidx_reg == '0 && pbyte_reg == '0 && flen_reg == '0 && chk_reg == '0)
    `LPFR_ASSERT_IMPL(a_count_outside_payload, clk, rst_n,
                      phase_reg != PH_PAYLOAD && phase_reg != PH_LEN_LO, count_reg == '0)

endmodule

/* verif/lpfr_checker.sv */
// ----------------------------------------------------------------------------
// lpfr_checker
// watches the byte and result channels of the frame receiver, follows the
// frame format byte by byte to predict one result per accepted byte, and
// compares every result transaction field by field with the oldest prediction
// ----------------------------------------------------------------------------
module lpfr_checker
(
    input  logic   clk,
    input  logic   rst_n,
    lpfr_byte_if   rx,
    lpfr_result_if result,
    output int     mismatch_count,
    output int     results_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PH_WAIT_HASH,
        PH_WAIT_BANG,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_WAIT_STAR,
        PH_CHECK,
        PH_WAIT_AMP
    } parse_phase_t;

    typedef struct packed {
        lpfr_pkg::kind_t                 kind;
        logic [lpfr_pkg::LEN_W-1:0]  payload_index;
        logic [lpfr_pkg::BYTE_W-1:0] payload_byte;
        logic [lpfr_pkg::LEN_W-1:0]  frame_length;
        logic [lpfr_pkg::BYTE_W-1:0] check_byte;
    } frame_result_t;

    parse_phase_t                phase;
    logic [lpfr_pkg::LEN_W-1:0]  declared_len;
    logic [lpfr_pkg::LEN_W-1:0]  payload_count;
    logic [lpfr_pkg::BYTE_W-1:0] captured_check;
    frame_result_t               expected_results[$];
    frame_result_t               oldest;

    function automatic frame_result_t parse_rx_byte(input logic [lpfr_pkg::BYTE_W-1:0] b);
        frame_result_t r;
        r = '0;
        r.kind = lpfr_pkg::KIND_NONE;
        case (phase)
            PH_WAIT_HASH:
            begin
                if (b == lpfr_pkg::MARK_HASH)
                    phase = PH_WAIT_BANG;
            end
            PH_WAIT_BANG:
            begin
                if (b == lpfr_pkg::MARK_BANG)
                    phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                declared_len = {b, 8'h00};
                phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                declared_len = {declared_len[15:8], b};
                payload_count = '0;
                // zero length skips the payload
                phase = (declared_len == '0) ? PH_WAIT_STAR : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                r.kind = lpfr_pkg::KIND_PAYLOAD;
                r.payload_index = payload_count;
                r.payload_byte = b;
                if (32'(payload_count) + 1 >= 32'(declared_len))
                begin
                    payload_count = '0;
                    phase = PH_WAIT_STAR;
                end
                else
                begin
                    payload_count = payload_count + 1'b1;
                end
            end
            PH_WAIT_STAR:
            begin
                if (b == lpfr_pkg::MARK_STAR)
                    phase = PH_CHECK;
            end
            PH_CHECK:
            begin
                captured_check = b;
                phase = PH_WAIT_AMP;
            end
            default:
            begin
                if (b == lpfr_pkg::MARK_AMP)
                begin
                    r.kind = lpfr_pkg::KIND_DONE;
                    r.frame_length = declared_len;
                    r.check_byte = captured_check;
                    phase = PH_WAIT_HASH;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = PH_WAIT_HASH;
            declared_len = '0;
            payload_count = '0;
            captured_check = '0;
            expected_results.delete();
            mismatch_count = 0;
            results_outstanding <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no expected result");
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result.kind !== oldest.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", oldest.kind, result.kind);
                        mismatch_count++;
                    end
                    if (result.payload_index !== oldest.payload_index)
                    begin
                        $error("payload_index: expected %0d, actual %0d",
                               oldest.payload_index, result.payload_index);
                        mismatch_count++;
                    end
                    if (result.payload_byte !== oldest.payload_byte)
                    begin
                        $error("payload_byte: expected %02h, actual %02h",
                               oldest.payload_byte, result.payload_byte);
                        mismatch_count++;
                    end
                    if (result.frame_length !== oldest.frame_length)
                    begin
                        $error("frame_length: expected %0d, actual %0d",
                               oldest.frame_length, result.frame_length);
                        mismatch_count++;
                    end
                    if (result.check_byte !== oldest.check_byte)
                    begin
                        $error("check_byte: expected %02h, actual %02h",
                               oldest.check_byte, result.check_byte);
                        mismatch_count++;
                    end
                end
            end
            if (rx.valid && rx.ready)
                expected_results.push_back(parse_rx_byte(rx.rx_byte));
            results_outstanding <= expected_results.size();
        end
    end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// top of the frame receiver testbench: drives a directed byte sequence and
// then random frames, broken frames and noise with random gaps and result
// stalls; the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 650;
    localparam int CALM_AFTER     = 550;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    bit   idle_en;
    int   mismatch_count;
    int   results_outstanding;
    int   idle_cycles;
    int   items_sent;

    lpfr_byte_if   rx_ch ();
    lpfr_result_if res_ch ();

    length_prefixed_frame_receiver uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    lpfr_checker checker_i
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .rx                  (rx_ch),
        .result              (res_ch),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic send_byte(input logic [lpfr_pkg::BYTE_W-1:0] b);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_results();
        rx_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_outstanding != 0);
    endtask

    function automatic logic [lpfr_pkg::BYTE_W-1:0] byte_other_than(
        input logic [lpfr_pkg::BYTE_W-1:0] m);
        logic [lpfr_pkg::BYTE_W-1:0] b;
        do
            b = lpfr_pkg::BYTE_W'($urandom_range(0, 255));
        while (b == m);
        return b;
    endfunction

    function automatic logic [lpfr_pkg::BYTE_W-1:0] payload_value();
        logic [lpfr_pkg::BYTE_W-1:0] b;
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 3))
                0: b = lpfr_pkg::MARK_HASH;
                1: b = lpfr_pkg::MARK_BANG;
                2: b = lpfr_pkg::MARK_STAR;
                default: b = lpfr_pkg::MARK_AMP;
            endcase
        end
        else
        begin
            b = lpfr_pkg::BYTE_W'($urandom_range(0, 255));
        end
        return b;
    endfunction

    // truncated frames drop the closing marker
    task automatic send_frame(input int unsigned len, input bit truncated);
        logic [lpfr_pkg::LEN_W-1:0] l;
        l = lpfr_pkg::LEN_W'(len);
        if ($urandom_range(0, 2) == 0)
            send_byte(byte_other_than(lpfr_pkg::MARK_HASH));
        send_byte(lpfr_pkg::MARK_HASH);
        if ($urandom_range(0, 3) == 0)
            send_byte(byte_other_than(lpfr_pkg::MARK_BANG));
        send_byte(lpfr_pkg::MARK_BANG);
        send_byte(l[15:8]);
        send_byte(l[7:0]);
        for (int unsigned i = 0; i < len; i++)
            send_byte(payload_value());
        if ($urandom_range(0, 3) == 0)
            send_byte(byte_other_than(lpfr_pkg::MARK_STAR));
        send_byte(lpfr_pkg::MARK_STAR);
        send_byte(payload_value());
        if ($urandom_range(0, 3) == 0)
            send_byte(byte_other_than(lpfr_pkg::MARK_AMP));
        if (!truncated)
            send_byte(lpfr_pkg::MARK_AMP);
    endtask

    // result side stalls in random bursts
    initial
    begin
        res_ch.ready <= 1'b0;
        repeat (6) @(posedge clk);
        forever
        begin
            if (idle_en && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** length_prefixed_frame_receiver: FAILED **");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
        else
        begin
            idle_cycles <= 0;
        end
    end

    initial
    begin
        logic [lpfr_pkg::BYTE_W-1:0] directed_bytes[25];
        int unsigned                 n;
        int unsigned                 len;
        bit                          long_done;
        bit                          paused;

        directed_bytes = '{
            // noise and markers out of order while idle
            8'h00, 8'hFF, lpfr_pkg::MARK_BANG, lpfr_pkg::MARK_STAR,
            // zero length frame with noise in every wait
            lpfr_pkg::MARK_HASH, lpfr_pkg::MARK_HASH, 8'hFF, lpfr_pkg::MARK_BANG,
            8'h00, 8'h00,
            lpfr_pkg::MARK_AMP, lpfr_pkg::MARK_STAR, 8'h00, lpfr_pkg::MARK_HASH,
            lpfr_pkg::MARK_AMP,
            // short frame with extreme payload bytes and a marker inside
            lpfr_pkg::MARK_HASH, lpfr_pkg::MARK_BANG, 8'h00, 8'h03, 8'h00, 8'hFF,
            lpfr_pkg::MARK_AMP,
            lpfr_pkg::MARK_STAR, 8'hFF, lpfr_pkg::MARK_AMP
        };
        rst_n <= 1'b0;
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= '0;
        idle_en = 1'b1;
        items_sent = 0;
        long_done = 1'b0;
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        wait_for_results();

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= CALM_AFTER)
                idle_en = 1'b0;
            if (!long_done && items_sent >= 250)
            begin
                send_frame(256 + $urandom_range(0, 63), 1'b0);
                long_done = 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 10);
                repeat (n) send_byte(lpfr_pkg::BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: len = 0;
                    1: len = $urandom_range(16, 40);
                    default: len = $urandom_range(1, 8);
                endcase
                send_frame(len, $urandom_range(0, 9) == 0);
            end
            if (!paused && items_sent >= 400)
            begin
                wait_for_results();
                paused = 1'b1;
            end
        end

        wait_for_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("** length_prefixed_frame_receiver: PASSED **");
        else
            $display("** length_prefixed_frame_receiver: FAILED **");
        $finish;
    end

endmodule
